// File: hdl/tlas_pkg.sv
package tlas_pkg;

  localparam int TIME_FIELD_BITS  = 16;
  localparam int SUM_BITS         = 24;
  localparam int PATH_BITS        = 64;
  localparam int COUNT_BITS       = 7;
  localparam int CFG_INDEX_BITS   = 2;
  localparam int MAX_STATIONS_DEF = 64;
  localparam int TIME_BITS_DEF    = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_ENTRY_ONE = 2'd0,
    CFG_ENTRY_TWO = 2'd1,
    CFG_EXIT_ONE  = 2'd2,
    CFG_EXIT_TWO  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [TIME_FIELD_BITS-1:0] work_time_line_one;
    logic [TIME_FIELD_BITS-1:0] work_time_line_two;
    logic [TIME_FIELD_BITS-1:0] move_cost_into_two;
    logic [TIME_FIELD_BITS-1:0] move_cost_into_one;
    logic                       first_station;
    logic                       last_station;
  } station_t;

  typedef struct packed {
    logic [SUM_BITS-1:0]   total_time;
    logic                  exit_line;
    logic [PATH_BITS-1:0]  chosen_lines;
    logic [COUNT_BITS-1:0] station_count;
    logic                  too_many_stations;
  } result_t;

  typedef struct packed {
    logic [SUM_BITS-1:0]   best_time_one;
    logic [SUM_BITS-1:0]   best_time_two;
    logic [PATH_BITS-1:0]  survivor_path_one;
    logic [PATH_BITS-1:0]  survivor_path_two;
    logic [COUNT_BITS-1:0] station_index;
    logic                  overflow_seen;
  } sched_state_t;

  function automatic logic [SUM_BITS-1:0] sat_sum(input logic [SUM_BITS:0] v);
    sat_sum = v[SUM_BITS] ? {SUM_BITS{1'b1}} : v[SUM_BITS-1:0];
  endfunction

endpackage

// File: hdl/tlas_step.sv
module tlas_step import tlas_pkg::*; #(
  parameter int MAX_STATIONS = MAX_STATIONS_DEF,
  parameter int TIME_BITS    = TIME_BITS_DEF
) (
  input  station_t                   station,
  input  sched_state_t               cur,
  input  logic [TIME_FIELD_BITS-1:0] entry_one,
  input  logic [TIME_FIELD_BITS-1:0] entry_two,
  output sched_state_t               nxt
);

  localparam int TW = (TIME_BITS < TIME_FIELD_BITS) ? TIME_BITS : TIME_FIELD_BITS;

  logic [TW-1:0]         w1;
  logic [TW-1:0]         w2;
  logic [TW-1:0]         m1;
  logic [TW-1:0]         m2;
  logic [SUM_BITS:0]     stay1;
  logic [SUM_BITS:0]     move1;
  logic [SUM_BITS:0]     stay2;
  logic [SUM_BITS:0]     move2;
  logic [SUM_BITS:0]     n1;
  logic [SUM_BITS:0]     n2;
  logic [PATH_BITS-1:0]  p1;
  logic [PATH_BITS-1:0]  p2;
  logic [PATH_BITS-1:0]  bit_mask;
  logic                  has_room;

  assign w1 = station.work_time_line_one[TW-1:0];
  assign w2 = station.work_time_line_two[TW-1:0];
  assign m1 = station.move_cost_into_one[TW-1:0];
  assign m2 = station.move_cost_into_two[TW-1:0];

  assign stay1 = {1'b0, cur.best_time_one} + (SUM_BITS+1)'(w1);
  assign move1 = {1'b0, cur.best_time_two} + (SUM_BITS+1)'(m1) + (SUM_BITS+1)'(w1);
  assign stay2 = {1'b0, cur.best_time_two} + (SUM_BITS+1)'(w2);
  assign move2 = {1'b0, cur.best_time_one} + (SUM_BITS+1)'(m2) + (SUM_BITS+1)'(w2);

  assign bit_mask = PATH_BITS'(1) << cur.station_index;
  assign has_room = cur.station_index < COUNT_BITS'(MAX_STATIONS);

  always_comb begin
    n1 = stay1;
    p1 = cur.survivor_path_one;
    n2 = stay2;
    p2 = cur.survivor_path_two;
    if (stay1 > move1) begin
      n1 = move1;
      p1 = cur.survivor_path_two;
    end
    if (stay2 > move2) begin
      n2 = move2;
      p2 = cur.survivor_path_one;
    end

    nxt = cur;
    if (station.first_station) begin
      nxt.best_time_one     = sat_sum((SUM_BITS+1)'(entry_one[TW-1:0]) + (SUM_BITS+1)'(w1));
      nxt.best_time_two     = sat_sum((SUM_BITS+1)'(entry_two[TW-1:0]) + (SUM_BITS+1)'(w2));
      nxt.survivor_path_one = '0;
      nxt.survivor_path_two = PATH_BITS'(1);
      nxt.station_index     = COUNT_BITS'(1);
      nxt.overflow_seen     = 1'b0;
    end else begin
      nxt.best_time_one = sat_sum(n1);
      nxt.best_time_two = sat_sum(n2);
      if (has_room) begin
        nxt.survivor_path_one = p1 & ~bit_mask;
        nxt.survivor_path_two = p2 | bit_mask;
        nxt.station_index     = cur.station_index + COUNT_BITS'(1);
      end else begin
        nxt.survivor_path_one = p1;
        nxt.survivor_path_two = p2;
        nxt.overflow_seen     = 1'b1;
      end
    end
  end

endmodule

// File: hdl/two_line_assembly_schedule.sv
// Two-line assembly scheduler. Stations stream in one transaction per cycle, the
// first marked by first_station and the last by last_station; the block keeps the
// best arrival time and survivor path for each line and, on the last station, emits
// one result with the total time (entry and exit included, saturated to 24 bits),
// the exit line and the line used at each station. A station is accepted every
// cycle unless a finished schedule is waiting behind a result that has not yet been
// taken; a last station passes the station, finished-state and result registers
// (recurrence and state update, then exit add and compare); the state recurrence
// sets the rate. The user must write entry and exit costs through the cfg channel,
// always ready, only while no schedule is in flight; the block does not enforce it.
module two_line_assembly_schedule import tlas_pkg::*; #(
  parameter int MAX_STATIONS = MAX_STATIONS_DEF,
  parameter int TIME_BITS    = TIME_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       station_valid,
  output logic                       station_ready,
  input  station_t                   station,
  output logic                       result_valid,
  input  logic                       result_ready,
  output result_t                    result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [TIME_FIELD_BITS-1:0] cfg_data
);

  localparam int TW = (TIME_BITS < TIME_FIELD_BITS) ? TIME_BITS : TIME_FIELD_BITS;

  logic [TIME_FIELD_BITS-1:0] entry_one;
  logic [TIME_FIELD_BITS-1:0] entry_two;
  logic [TIME_FIELD_BITS-1:0] exit_one;
  logic [TIME_FIELD_BITS-1:0] exit_two;

  logic         out_free;
  logic         advance;
  logic         stn_valid;
  station_t     stn;
  sched_state_t state;
  sched_state_t state_next;
  logic         fin_valid;
  sched_state_t fin;
  logic [SUM_BITS:0] t1;
  logic [SUM_BITS:0] t2;
  logic         pick_one;

  assign out_free      = !result_valid || result_ready;
  assign advance       = out_free || !fin_valid;
  assign station_ready = advance;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_one <= '0;
      entry_two <= '0;
      exit_one  <= '0;
      exit_two  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ENTRY_ONE: entry_one <= cfg_data;
        CFG_ENTRY_TWO: entry_two <= cfg_data;
        CFG_EXIT_ONE:  exit_one  <= cfg_data;
        CFG_EXIT_TWO:  exit_two  <= cfg_data;
        default:       entry_one <= entry_one;
      endcase
    end
  end

  tlas_step #(
    .MAX_STATIONS (MAX_STATIONS),
    .TIME_BITS    (TIME_BITS)
  ) u_step (
    .station   (stn),
    .cur       (state),
    .entry_one (entry_one),
    .entry_two (entry_two),
    .nxt       (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stn_valid <= 1'b0;
    end else if (advance) begin
      stn_valid <= station_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stn <= station;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      fin_valid <= 1'b0;
    end else if (advance) begin
      fin_valid <= stn_valid && stn.last_station;
      if (stn_valid) begin
        state <= stn.last_station ? '0 : state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fin <= state_next;
    end
  end

  assign t1       = {1'b0, fin.best_time_one} + (SUM_BITS+1)'(exit_one[TW-1:0]);
  assign t2       = {1'b0, fin.best_time_two} + (SUM_BITS+1)'(exit_two[TW-1:0]);
  assign pick_one = t1 <= t2;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      result.total_time        <= sat_sum(pick_one ? t1 : t2);
      result.exit_line         <= !pick_one;
      result.chosen_lines      <= pick_one ? fin.survivor_path_one : fin.survivor_path_two;
      result.station_count     <= fin.station_index;
      result.too_many_stations <= fin.overflow_seen;
    end
  end

  a_index_bounded: assert property (@(posedge clk) disable iff (rst)
    state.station_index <= COUNT_BITS'(MAX_STATIONS))
    else $error("station index beyond capacity");

  a_overflow_at_cap: assert property (@(posedge clk) disable iff (rst)
    state.overflow_seen |-> state.station_index == COUNT_BITS'(MAX_STATIONS))
    else $error("overflow flagged below capacity");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    advance && stn_valid && stn.last_station
      |=> state.station_index == '0 && !state.overflow_seen)
    else $error("schedule state not cleared after last station");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance && fin_valid |=> result_valid)
    else $error("finished schedule lost before result register");

endmodule

// File: dv/two_line_assembly_schedule_tb.sv
module two_line_assembly_schedule_tb;
  import tlas_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 8;
  localparam int WIDE_BITS     = SUM_BITS + 2;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       station_valid = 1'b0;
  logic                       station_ready;
  station_t                   station = '0;
  logic                       result_valid;
  logic                       result_ready = 1'b0;
  result_t                    result;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_BITS-1:0]  cfg_index = CFG_ENTRY_ONE;
  logic [TIME_FIELD_BITS-1:0] cfg_data = '0;

  two_line_assembly_schedule dut (
    .clk           (clk),
    .rst           (rst),
    .station_valid (station_valid),
    .station_ready (station_ready),
    .station       (station),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // predictor copy of the costs and the running schedule
  logic [TIME_FIELD_BITS-1:0] entry_one, entry_two, exit_one, exit_two;
  logic [SUM_BITS-1:0]        best_one, best_two;
  logic [PATH_BITS-1:0]       route_one, route_two;
  logic [COUNT_BITS-1:0]      stations_seen;
  logic                       overflowed;

  result_t due_schedules[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int stations_sent = 0;
  int schedules_checked = 0;
  int cost_settings = 1;

  function automatic logic [SUM_BITS-1:0] clamp_time(input logic [SUM_BITS+1:0] v);
    return (v > {2'b00, {SUM_BITS{1'b1}}}) ? {SUM_BITS{1'b1}} : v[SUM_BITS-1:0];
  endfunction

  function automatic void clear_schedule();
    best_one = '0;
    best_two = '0;
    route_one = '0;
    route_two = '0;
    stations_seen = '0;
    overflowed = 1'b0;
  endfunction

  function automatic void advance_schedule(input station_t s);
    logic [SUM_BITS+1:0]  stay1, move1, stay2, move2, next1, next2, done1, done2;
    logic [PATH_BITS-1:0] path1, path2;
    result_t              r;
    if (s.first_station) begin
      best_one = clamp_time(WIDE_BITS'(entry_one) + WIDE_BITS'(s.work_time_line_one));
      best_two = clamp_time(WIDE_BITS'(entry_two) + WIDE_BITS'(s.work_time_line_two));
      route_one = '0;
      route_two = 64'd1;
      stations_seen = 7'd1;
      overflowed = 1'b0;
    end else begin
      stay1 = WIDE_BITS'(best_one) + WIDE_BITS'(s.work_time_line_one);
      move1 = WIDE_BITS'(best_two) + WIDE_BITS'(s.move_cost_into_one)
              + WIDE_BITS'(s.work_time_line_one);
      stay2 = WIDE_BITS'(best_two) + WIDE_BITS'(s.work_time_line_two);
      move2 = WIDE_BITS'(best_one) + WIDE_BITS'(s.move_cost_into_two)
              + WIDE_BITS'(s.work_time_line_two);
      if (stay1 <= move1) begin
        next1 = stay1;
        path1 = route_one;
      end else begin
        next1 = move1;
        path1 = route_two;
      end
      if (stay2 <= move2) begin
        next2 = stay2;
        path2 = route_two;
      end else begin
        next2 = move2;
        path2 = route_one;
      end
      if (stations_seen < COUNT_BITS'(MAX_STATIONS_DEF)) begin
        path1[stations_seen[5:0]] = 1'b0;
        path2[stations_seen[5:0]] = 1'b1;
        stations_seen = stations_seen + 7'd1;
      end else begin
        overflowed = 1'b1;
      end
      best_one = clamp_time(next1);
      best_two = clamp_time(next2);
      route_one = path1;
      route_two = path2;
    end
    if (s.last_station) begin
      done1 = WIDE_BITS'(best_one) + WIDE_BITS'(exit_one);
      done2 = WIDE_BITS'(best_two) + WIDE_BITS'(exit_two);
      if (done1 <= done2) begin
        r.total_time = clamp_time(done1);
        r.exit_line = 1'b0;
        r.chosen_lines = route_one;
      end else begin
        r.total_time = clamp_time(done2);
        r.exit_line = 1'b1;
        r.chosen_lines = route_two;
      end
      r.station_count = stations_seen;
      r.too_many_stations = overflowed;
      due_schedules.push_back(r);
      clear_schedule();
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (due_schedules.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none actual %0h", $time, result);
      end else begin
        want = due_schedules.pop_front();
        check_field("total_time", 64'(want.total_time), 64'(result.total_time));
        check_field("exit_line", 64'(want.exit_line), 64'(result.exit_line));
        check_field("chosen_lines", want.chosen_lines, result.chosen_lines);
        check_field("station_count", 64'(want.station_count), 64'(result.station_count));
        check_field("too_many_stations", 64'(want.too_many_stations),
                    64'(result.too_many_stations));
        schedules_checked++;
      end
    end
  end

  task automatic send_station(input station_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      station_valid <= 1'b0;
      @(posedge clk);
    end
    station_valid <= 1'b1;
    station <= s;
    @(posedge clk);
    while (!station_ready) @(posedge clk);
    advance_schedule(s);
    stations_sent++;
  endtask

  // hold until every result is in and the pipeline has drained
  task automatic settle();
    station_valid <= 1'b0;
    while (due_schedules.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t which, input logic [TIME_FIELD_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    unique case (which)
      CFG_ENTRY_ONE: entry_one = value;
      CFG_ENTRY_TWO: entry_two = value;
      CFG_EXIT_ONE:  exit_one = value;
      CFG_EXIT_TWO:  exit_two = value;
    endcase
  endtask

  task automatic write_costs(input logic [15:0] e1, input logic [15:0] e2,
                             input logic [15:0] x1, input logic [15:0] x2);
    write_reg(CFG_ENTRY_ONE, e1);
    write_reg(CFG_ENTRY_TWO, e2);
    write_reg(CFG_EXIT_ONE, x1);
    write_reg(CFG_EXIT_TWO, x2);
    cfg_valid <= 1'b0;
    cost_settings++;
  endtask

  function automatic station_t make_station(input logic [15:0] w1, input logic [15:0] w2,
                                            input logic [15:0] m2, input logic [15:0] m1,
                                            input logic first, input logic last);
    station_t s;
    s.work_time_line_one = w1;
    s.work_time_line_two = w2;
    s.move_cost_into_two = m2;
    s.move_cost_into_one = m1;
    s.first_station = first;
    s.last_station = last;
    return s;
  endfunction

  function automatic logic [15:0] rand_time();
    case ($urandom_range(3))
      0: return 16'($urandom_range(16'hFFFF));
      1: return 16'($urandom_range(7));
      2: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'hFFFF - 16'($urandom_range(15));
    endcase
  endfunction

  function automatic station_t random_station(input logic first, input logic last);
    return make_station(rand_time(), rand_time(), rand_time(), rand_time(), first, last);
  endfunction

  task automatic test_single_station();
    send_station(make_station(16'd7, 16'd3, 16'd1, 16'd1, 1'b1, 1'b1));
    settle();
    write_costs(16'd5, 16'd9, 16'd3, 16'd2);
    send_station(make_station(16'd10, 16'd4, 16'd0, 16'd0, 1'b1, 1'b1));
    send_station(make_station(16'd10, 16'd7, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    send_station(make_station(16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
    settle();
    write_costs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_station(make_station(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    send_station(make_station(16'hFFFF, 16'hFFFE, 16'h0000, 16'h0000, 1'b1, 1'b1));
    settle();
  endtask

  task automatic test_moves_and_ties();
    write_costs(16'd0, 16'd0, 16'd0, 16'd0);
    send_station(make_station(16'd1, 16'd1, 16'd9, 16'd9, 1'b1, 1'b0));
    send_station(make_station(16'd5, 16'd5, 16'd0, 16'd0, 1'b0, 1'b0));
    send_station(make_station(16'd1, 16'd100, 16'd0, 16'd2, 1'b0, 1'b0));
    send_station(make_station(16'd100, 16'd1, 16'd0, 16'd0, 1'b0, 1'b0));
    send_station(make_station(16'd3, 16'd3, 16'd1, 16'd1, 1'b0, 1'b1));
    send_station(make_station(16'd4, 16'd2, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
    send_station(make_station(16'd2, 16'd4, 16'd2, 16'd2, 1'b0, 1'b1));
    settle();
  endtask

  task automatic test_missing_first();
    write_costs(16'd40, 16'd3, 16'd0, 16'd50);
    send_station(make_station(16'd6, 16'd2, 16'd1, 16'd4, 1'b0, 1'b0));
    send_station(make_station(16'd1, 16'd9, 16'd3, 16'd0, 1'b0, 1'b0));
    send_station(make_station(16'd2, 16'd2, 16'd0, 16'd0, 1'b0, 1'b1));
    send_station(make_station(16'd8, 16'd1, 16'd0, 16'd0, 1'b0, 1'b0));
    send_station(make_station(16'd1, 16'd8, 16'd0, 16'd0, 1'b0, 1'b1));
    send_station(make_station(16'd5, 16'd5, 16'd5, 16'd5, 1'b0, 1'b1));
    settle();
  endtask

  task automatic test_station_limit();
    for (int n = MAX_STATIONS_DEF - 1; n <= MAX_STATIONS_DEF + 1; n++) begin
      for (int i = 0; i < n; i++) begin
        send_station(make_station(16'($urandom_range(7)), 16'($urandom_range(7)),
                                  16'($urandom_range(3)), 16'($urandom_range(3)),
                                  i == 0, i == n - 1));
      end
    end
    settle();
  endtask

  task automatic test_time_saturation();
    write_costs(16'hFFFF, 16'hFFF0, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 260; i++) begin
      send_station(make_station(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, i == 0, i == 259));
    end
    for (int i = 0; i < 256; i++) begin
      send_station(make_station(16'hFFFF, 16'hFFFE, 16'h0000, 16'hFFFF, i == 0, i == 255));
    end
    settle();
  endtask

  // mostly well-formed schedules, some without a first station, some with stray flags
  task automatic test_random_schedules(input int budget);
    int   sent;
    int   length;
    int   kind;
    int   pick;
    logic first;
    logic last;
    sent = 0;
    while (sent < budget) begin
      kind = $urandom_range(99);
      pick = $urandom_range(99);
      if (pick < 80) length = $urandom_range(8, 1);
      else if (pick < 95) length = $urandom_range(64, 9);
      else length = $urandom_range(80, 65);
      for (int i = 0; i < length; i++) begin
        if (kind < 85) first = (i == 0);
        else if (kind < 93) first = 1'b0;
        else first = ($urandom_range(7) == 0);
        last = (i == length - 1) || (kind >= 93 && $urandom_range(7) == 0);
        send_station(random_station(first, last));
      end
      sent += length;
    end
    settle();
  endtask

  initial begin
    entry_one = '0;
    entry_two = '0;
    exit_one = '0;
    exit_two = '0;
    clear_schedule();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 12;
    recv_idle_pct = 77;
    test_single_station();
    test_moves_and_ties();
    test_missing_first();
    test_station_limit();
    test_time_saturation();

    write_costs(rand_time(), rand_time(), rand_time(), rand_time());
    test_random_schedules(250);

    send_idle_pct = 77;
    recv_idle_pct = 12;
    write_costs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_random_schedules(230);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_costs(16'h0000, 16'hFFFF, rand_time(), rand_time());
    test_random_schedules(250);

    if (due_schedules.size() != 0) begin
      mismatches += due_schedules.size();
      $display("%0t: %0d results expected but never delivered", $time, due_schedules.size());
    end
    $display("Sent %0d stations under %0d cost settings; %0d schedule results compared.",
             stations_sent, cost_settings, schedules_checked);
    $display("Covered ties, line moves, missing first stations, path overflow and saturation.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d results outstanding", due_schedules.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
